// File: sv/pf2rgb_pkg.sv
// Shared types, constants and the 10-to-8-bit channel conversion for the
// pixel format converter. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pf2rgb_pkg;

  // source pixel layouts, as written to the layout register
  typedef enum logic [1:0] {
    LAYOUT_BGRA8 = 2'd0,
    LAYOUT_RGBA8 = 2'd1,
    LAYOUT_A2B10 = 2'd2,
    LAYOUT_A2R10 = 2'd3
  } layout_t;

  // register index, taken from cfg_paddr[3:2]
  typedef enum logic [1:0] {
    REG_LAYOUT = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } reg_idx_t;

  localparam int DIM_REG_W = 13;   // width/height register bits
  localparam int OFF_W     = 26;   // destination byte offset bits
  localparam int QDEPTH    = 4;    // front-to-back queue depth, power of two
  localparam int QPTR_W    = 2;
  localparam int QCNT_W    = 3;

  // channels as classified by the front end; 8-bit layouts sit in c[7:0]
  typedef struct packed {
    logic       is10;
    logic [9:0] blue;
    logic [9:0] green;
    logic [9:0] red;
  } pix_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_status_t;

  // (v*255+511)/1023; x/1023 == (x + (x>>10) + 1) >> 10 for x < 1023*1024
  function automatic logic [7:0] ten_to_eight(input logic [9:0] v);
    logic [17:0] x;
    logic [17:0] s;
    x = {v, 8'b0} - {8'b0, v} + 18'd511;
    s = x + {10'b0, x[17:10]} + 18'd1;
    return s[17:10];
  endfunction

endpackage

`default_nettype wire

// File: sv/pf2rgb_front.sv
// Front end: accepts source pixel words, decodes the channel layout and
// tracks column/row for the flipped destination. Uses pf2rgb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pf2rgb_front #(
  parameter int CNTW = 12
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [31:0]          in_data,
  input  wire pf2rgb_pkg::layout_t  layout,
  input  wire logic [CNTW-1:0]      wm1,
  input  wire logic [CNTW-1:0]      hm1,
  input  wire pf2rgb_pkg::q_status_t q_st,
  output logic                      push,
  output pf2rgb_pkg::pix_t          push_pix,
  output logic [CNTW-1:0]           push_inv_row,
  output logic [CNTW-1:0]           push_col,
  output logic                      push_last
);

  logic [CNTW-1:0] col_cnt_r, col_cnt_nxt;
  logic [CNTW-1:0] row_cnt_r, row_cnt_nxt;
  logic            row_end;
  logic            frame_end;
  logic [CNTW-1:0] row_clamp;

  assign in_ready = !q_st.full;
  assign push     = in_valid && !q_st.full;

  // a counter past the last column/row (dims shrunk mid-frame) is clamped
  assign row_end   = (col_cnt_r >= wm1);
  assign frame_end = row_end && (row_cnt_r >= hm1);
  assign row_clamp = (row_cnt_r < hm1) ? row_cnt_r : hm1;

  assign push_col     = (col_cnt_r < wm1) ? col_cnt_r : wm1;
  assign push_inv_row = hm1 - row_clamp;
  assign push_last    = frame_end;

  always_comb begin
    push_pix = '0;
    case (layout)
      pf2rgb_pkg::LAYOUT_BGRA8: begin
        push_pix.red   = {2'b0, in_data[23:16]};
        push_pix.green = {2'b0, in_data[15:8]};
        push_pix.blue  = {2'b0, in_data[7:0]};
      end
      pf2rgb_pkg::LAYOUT_RGBA8: begin
        push_pix.red   = {2'b0, in_data[7:0]};
        push_pix.green = {2'b0, in_data[15:8]};
        push_pix.blue  = {2'b0, in_data[23:16]};
      end
      pf2rgb_pkg::LAYOUT_A2B10: begin
        push_pix.is10  = 1'b1;
        push_pix.red   = in_data[9:0];
        push_pix.green = in_data[19:10];
        push_pix.blue  = in_data[29:20];
      end
      pf2rgb_pkg::LAYOUT_A2R10: begin
        push_pix.is10  = 1'b1;
        push_pix.red   = in_data[29:20];
        push_pix.green = in_data[19:10];
        push_pix.blue  = in_data[9:0];
      end
      default: begin
        push_pix = '0;
      end
    endcase
  end

  always_comb begin
    col_cnt_nxt = col_cnt_r;
    row_cnt_nxt = row_cnt_r;
    if (push) begin
      if (row_end) begin
        col_cnt_nxt = '0;
        row_cnt_nxt = frame_end ? '0 : row_cnt_r + 1'b1;
      end else begin
        col_cnt_nxt = col_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/pf2rgb_fifo.sv
// Short register queue between front and back ends.
// Uses pf2rgb_pkg for depth and status type.
`timescale 1ns / 1ps
`default_nettype none

module pf2rgb_fifo #(
  parameter int W = 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   push,
  input  wire logic [W-1:0]           wdata,
  input  wire logic                   pop,
  output logic [W-1:0]                rdata,
  output pf2rgb_pkg::q_status_t       status
);

  logic [W-1:0] mem_r [pf2rgb_pkg::QDEPTH];
  logic [pf2rgb_pkg::QPTR_W-1:0] wptr_r, wptr_nxt;
  logic [pf2rgb_pkg::QPTR_W-1:0] rptr_r, rptr_nxt;
  logic [pf2rgb_pkg::QCNT_W-1:0] count_r, count_nxt;

  assign rdata        = mem_r[rptr_r];
  assign status.count = count_r;
  assign status.empty = (count_r == '0);
  assign status.full  = (count_r == pf2rgb_pkg::QCNT_W'(pf2rgb_pkg::QDEPTH));

  always_comb begin
    wptr_nxt  = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt  = pop  ? rptr_r + 1'b1 : rptr_r;
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

// File: sv/pf2rgb_back.sv
// Back end: offset multiply stage, then channel conversion, offset finish
// and the output register. Uses pf2rgb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pf2rgb_back #(
  parameter int CNTW = 12,
  parameter int DW   = 13
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire pf2rgb_pkg::q_status_t    q_st,
  input  wire pf2rgb_pkg::pix_t         q_pix,
  input  wire logic [CNTW-1:0]          q_inv_row,
  input  wire logic [CNTW-1:0]          q_col,
  input  wire logic                     q_last,
  output logic                          pop,
  input  wire logic [DW-1:0]            w,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [7:0]                    red,
  output logic [7:0]                    green,
  output logic [7:0]                    blue,
  output logic [pf2rgb_pkg::OFF_W-1:0]  offset,
  output logic                          last
);

  localparam int PW = CNTW + DW;
  localparam int SW = (PW + 3 > pf2rgb_pkg::OFF_W) ? PW + 3 : pf2rgb_pkg::OFF_W;

  logic                  adv;
  logic                  s1_valid_r, s1_valid_nxt;
  logic [PW-1:0]         prod_r;
  logic [CNTW-1:0]       col_r;
  pf2rgb_pkg::pix_t      pix_r;
  logic                  last_s1_r;

  logic                  out_valid_r, out_valid_nxt;
  logic [7:0]            red_r, green_r, blue_r;
  logic [7:0]            red_nxt, green_nxt, blue_nxt;
  logic [pf2rgb_pkg::OFF_W-1:0] off_r, off_nxt;
  logic                  last_r;
  logic [SW-1:0]         sum;
  logic [SW-1:0]         sum3;

  // whole back end moves together; stalls only when the output word waits
  assign adv = !out_valid_r || out_ready;
  assign pop = adv && !q_st.empty;

  assign s1_valid_nxt  = adv ? !q_st.empty : s1_valid_r;
  assign out_valid_nxt = adv ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // stage 1: row-from-bottom times width
  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r    <= PW'(q_inv_row) * PW'(w);
      col_r     <= q_col;
      pix_r     <= q_pix;
      last_s1_r <= q_last;
    end
  end

  // stage 2: add column, times 3, convert channels
  always_comb begin
    sum      = SW'(prod_r) + SW'(col_r);
    sum3     = (sum << 1) + sum;
    off_nxt  = sum3[pf2rgb_pkg::OFF_W-1:0];
    red_nxt   = pix_r.is10 ? pf2rgb_pkg::ten_to_eight(pix_r.red)   : pix_r.red[7:0];
    green_nxt = pix_r.is10 ? pf2rgb_pkg::ten_to_eight(pix_r.green) : pix_r.green[7:0];
    blue_nxt  = pix_r.is10 ? pf2rgb_pkg::ten_to_eight(pix_r.blue)  : pix_r.blue[7:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
      off_r   <= off_nxt;
      last_r  <= last_s1_r;
    end
  end

  assign out_valid = out_valid_r;
  assign red       = red_r;
  assign green     = green_r;
  assign blue      = blue_r;
  assign offset    = off_r;
  assign last      = last_r;

endmodule

`default_nettype wire

// File: sv/pixel_format_to_rgb888_flip_top.sv
// Top level of the pixel format converter with vertical flip: config
// registers, front end, queue and back end. Uses pf2rgb_pkg, pf2rgb_front,
// pf2rgb_fifo and pf2rgb_back.
//
//  channel | ports   | word
//  --------+---------+--------------------------------------------------
//  input   | in_     | 32-bit source pixel, byte 0 in bits 7:0
//  output  | out_    | red, green, blue, dst byte offset; tlast = last pixel
//  config  | cfg_    | APB; 0x0 layout, 0x4 width, 0x8 height
//
// One pixel per clock sustained while out_tready holds; each result passes
// through the queue, then the multiply stage, then the output register.
// A 4-word queue lets the input keep going while the output is stalled;
// in_tready drops only when it is full.
// Reset (synchronous) clears counters and queue; layout BGRA8, 1x1 image.
`timescale 1ns / 1ps
`default_nettype none

module pixel_format_to_rgb888_flip_top #(
  parameter int MAX_DIM = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,    // [31:0] pixel_word
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,   // [7:0] red, [15:8] green, [23:16] blue,
                                        // [49:24] dst_byte_offset, rest zero
  output logic             out_tlast,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int CNTW = $clog2(MAX_DIM);
  localparam int DW   = $clog2(MAX_DIM + 1);
  localparam int RW   = pf2rgb_pkg::DIM_REG_W;
  localparam int CW   = (DW > RW) ? DW : RW;
  localparam int QW   = $bits(pf2rgb_pkg::pix_t) + 2 * CNTW + 1;

  // ---------------- configuration registers ----------------
  pf2rgb_pkg::layout_t layout_r, layout_nxt;
  logic [RW-1:0]       width_r, width_nxt;
  logic [RW-1:0]       height_r, height_nxt;
  logic                cfg_wr;
  pf2rgb_pkg::reg_idx_t cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = pf2rgb_pkg::reg_idx_t'(cfg_paddr[3:2]);

  always_comb begin
    layout_nxt = layout_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_wr) begin
      case (cfg_idx)
        pf2rgb_pkg::REG_LAYOUT: layout_nxt = pf2rgb_pkg::layout_t'(cfg_pwdata[1:0]);
        pf2rgb_pkg::REG_WIDTH:  width_nxt  = cfg_pwdata[RW-1:0];
        pf2rgb_pkg::REG_HEIGHT: height_nxt = cfg_pwdata[RW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layout_r <= pf2rgb_pkg::LAYOUT_BGRA8;
      width_r  <= RW'(1);
      height_r <= RW'(1);
    end else begin
      layout_r <= layout_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  always_comb begin
    case (cfg_idx)
      pf2rgb_pkg::REG_LAYOUT: cfg_prdata = {30'b0, layout_r};
      pf2rgb_pkg::REG_WIDTH:  cfg_prdata = {{(32 - RW){1'b0}}, width_r};
      pf2rgb_pkg::REG_HEIGHT: cfg_prdata = {{(32 - RW){1'b0}}, height_r};
      default:                cfg_prdata = '0;
    endcase
  end

  // dims: zero is taken as 1, anything above MAX_DIM as MAX_DIM
  logic [CW-1:0]   w_ext, h_ext, w_dim, h_dim;
  logic [DW-1:0]   w;
  logic [CNTW-1:0] wm1, hm1;

  always_comb begin
    w_ext = CW'(width_r);
    h_ext = CW'(height_r);
    if (w_ext == '0) begin
      w_dim = CW'(1);
    end else if (w_ext > CW'(MAX_DIM)) begin
      w_dim = CW'(MAX_DIM);
    end else begin
      w_dim = w_ext;
    end
    if (h_ext == '0) begin
      h_dim = CW'(1);
    end else if (h_ext > CW'(MAX_DIM)) begin
      h_dim = CW'(MAX_DIM);
    end else begin
      h_dim = h_ext;
    end
  end

  logic [CW-1:0] w_dim_m1, h_dim_m1;
  assign w_dim_m1 = w_dim - CW'(1);
  assign h_dim_m1 = h_dim - CW'(1);
  assign w        = w_dim[DW-1:0];
  assign wm1      = w_dim_m1[CNTW-1:0];
  assign hm1      = h_dim_m1[CNTW-1:0];

  // ---------------- datapath ----------------
  pf2rgb_pkg::q_status_t q_st;
  logic                  q_push, q_pop;
  pf2rgb_pkg::pix_t      push_pix, q_pix;
  logic [CNTW-1:0]       push_inv_row, push_col, q_inv_row, q_col;
  logic                  push_last, q_last;
  logic [QW-1:0]         q_wdata, q_rdata;

  pf2rgb_front #(.CNTW(CNTW)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_data      (in_tdata),
    .layout       (layout_r),
    .wm1          (wm1),
    .hm1          (hm1),
    .q_st         (q_st),
    .push         (q_push),
    .push_pix     (push_pix),
    .push_inv_row (push_inv_row),
    .push_col     (push_col),
    .push_last    (push_last)
  );

  assign q_wdata = {push_last, push_col, push_inv_row, push_pix};

  pf2rgb_fifo #(.W(QW)) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .pop    (q_pop),
    .rdata  (q_rdata),
    .status (q_st)
  );

  assign {q_last, q_col, q_inv_row, q_pix} = q_rdata;

  logic [7:0]                   red, green, blue;
  logic [pf2rgb_pkg::OFF_W-1:0] offset;

  pf2rgb_back #(.CNTW(CNTW), .DW(DW)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_st      (q_st),
    .q_pix     (q_pix),
    .q_inv_row (q_inv_row),
    .q_col     (q_col),
    .q_last    (q_last),
    .pop       (q_pop),
    .w         (w),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .offset    (offset),
    .last      (out_tlast)
  );

  assign out_tdata = {{(56 - 24 - pf2rgb_pkg::OFF_W){1'b0}}, offset, blue, green, red};

  // ---------------- assertions ----------------
  a_queue_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && !q_pop) |=> (q_st.count == $past(q_st.count) + 1'b1))
    else $error("queue count did not advance on push");

  a_no_pop_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !q_pop)
    else $error("queue popped while output word stalled");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_st.empty)
    else $error("pop from empty queue");

endmodule

`default_nettype wire
